// ----- src/sfd_pkg.sv -----
// Package for the S.BUS frame decoder: shared constants, configuration register
// indexes and the frame record that travels from the front end to the back end.
// No dependencies.
package sfd_pkg;

    localparam int FRAME_LEN     = 25;
    localparam int NUM_CHANNELS  = 16;
    localparam int STORE_LEN     = FRAME_LEN - 1;
    localparam int FILL_W        = $clog2(STORE_LEN + 1);
    localparam int CH_W          = 11;
    localparam int CH_IDX_W      = $clog2(NUM_CHANNELS);
    localparam int CHAN_BITS     = CH_W * NUM_CHANNELS;
    localparam int CHAN_BYTES    = CHAN_BITS / 8;
    localparam int FLAGS_POS     = STORE_LEN - 1;
    localparam int QUEUE_DEPTH   = 2;

    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAILSAFE = 2'd2;

    localparam logic [7:0]      HEADER_RESET   = 8'h0F;
    localparam logic [7:0]      FOOTER_RESET   = 8'h00;
    localparam logic [CH_W-1:0] FAILSAFE_RESET = 11'd1072;
    localparam logic [7:0]      PREV_RESET     = 8'hFF;

    // Bit positions inside the flags byte.
    localparam int FLAG_CH17     = 0;
    localparam int FLAG_CH18     = 1;
    localparam int FLAG_LOST     = 2;
    localparam int FLAG_FAILSAFE = 3;

    // One decoded frame: channel payload bytes 1..22 little-endian, and flags.
    typedef struct packed {
        logic [CHAN_BITS-1:0] chan_bits;
        logic [3:0]           flags;
    } frame_t;

endpackage

// ----- src/sfd_front.sv -----
// Front end of the S.BUS frame decoder: byte fill, resync on header after
// footer, and frame capture on a footer once the store is full. Uses sfd_pkg.
module sfd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_accept,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          header_byte,
    input  logic [7:0]          footer_byte,
    output logic                frame_push,
    output sfd_pkg::frame_t     frame_data
);

    logic [sfd_pkg::FILL_W-1:0] fill_reg, fill_next, fill_eff;
    logic [7:0]                 prev_reg;
    logic [7:0]                 store_reg [sfd_pkg::STORE_LEN];
    logic                       resync;
    logic                       store_full;

    assign resync     = (prev_reg == footer_byte) && (rx_byte == header_byte);
    assign fill_eff   = resync ? '0 : fill_reg;
    assign store_full = (fill_eff >= sfd_pkg::FILL_W'(sfd_pkg::STORE_LEN));
    assign fill_next  = store_full ? fill_eff : fill_eff + 1'b1;
    assign frame_push = byte_accept && store_full && (rx_byte == footer_byte);

    // The store is read at fixed places only; the capture takes the channel bytes and flags byte together.
    always_comb begin
        for (int k = 0; k < sfd_pkg::CHAN_BYTES; k++) begin
            frame_data.chan_bits[8*k +: 8] = store_reg[k+1];
        end
        frame_data.flags = store_reg[sfd_pkg::FLAGS_POS][3:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            prev_reg <= sfd_pkg::PREV_RESET;
        end else if (byte_accept) begin
            fill_reg <= fill_next;
            prev_reg <= rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_accept && !store_full) begin
            store_reg[fill_eff] <= rx_byte;
        end
    end

endmodule

// ----- src/sfd_queue.sv -----
// Short frame queue between the decoder front end and back end.
// Uses sfd_pkg for the frame record.
module sfd_queue #(
    parameter int DEPTH = sfd_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sfd_pkg::frame_t push_data,
    input  logic            pop,
    output logic            not_empty,
    output logic            full,
    output sfd_pkg::frame_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfd_pkg::frame_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_data  = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/sfd_back.sv -----
// Back end of the S.BUS frame decoder: while the result register is free or read,
// shifts one 11-bit channel per cycle out of a loaded frame into it. Uses sfd_pkg.
module sfd_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        frame_avail,
    input  sfd_pkg::frame_t             frame_data,
    output logic                        frame_pop,
    input  logic [sfd_pkg::CH_W-1:0]    failsafe_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sfd_pkg::CH_IDX_W-1:0] m_channel_index,
    output logic [sfd_pkg::CH_W-1:0]    m_channel_value,
    output logic                        m_digital_ch17,
    output logic                        m_digital_ch18,
    output logic                        m_frame_lost,
    output logic                        m_failsafe_active,
    output logic                        m_last_channel
);

    logic                             busy_reg;
    logic [sfd_pkg::CHAN_BITS-1:0]    shift_reg;
    logic [3:0]                       flags_reg;
    logic [sfd_pkg::CH_IDX_W-1:0]     idx_reg;
    logic                             out_valid_reg;
    logic [sfd_pkg::CH_IDX_W-1:0]     out_idx_reg;
    logic [sfd_pkg::CH_W-1:0]         out_value_reg;
    logic [3:0]                       out_flags_reg;
    logic                             out_last_reg;
    logic                             advance;
    logic                             is_last;

    assign advance   = busy_reg && (!out_valid_reg || m_ready);
    assign is_last   = (idx_reg == sfd_pkg::CH_IDX_W'(sfd_pkg::NUM_CHANNELS - 1));
    assign frame_pop = frame_avail && (!busy_reg || (advance && is_last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (frame_pop) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (advance) begin
                busy_reg <= !is_last;
                idx_reg  <= idx_reg + 1'b1;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_pop) begin
            shift_reg <= frame_data.chan_bits;
            flags_reg <= frame_data.flags;
        end else if (advance) begin
            shift_reg <= shift_reg >> sfd_pkg::CH_W;
        end
        if (advance) begin
            out_idx_reg   <= idx_reg;
            out_value_reg <= flags_reg[sfd_pkg::FLAG_FAILSAFE] ? failsafe_value
                                                               : shift_reg[sfd_pkg::CH_W-1:0];
            out_flags_reg <= flags_reg;
            out_last_reg  <= is_last;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_channel_index   = out_idx_reg;
    assign m_channel_value   = out_value_reg;
    assign m_digital_ch17    = out_flags_reg[sfd_pkg::FLAG_CH17];
    assign m_digital_ch18    = out_flags_reg[sfd_pkg::FLAG_CH18];
    assign m_frame_lost      = out_flags_reg[sfd_pkg::FLAG_LOST];
    assign m_failsafe_active = out_flags_reg[sfd_pkg::FLAG_FAILSAFE];
    assign m_last_channel    = out_last_reg;

endmodule

// ----- src/sbus_frame_decoder.sv -----
// S.BUS frame decoder, top level. Takes one byte per cycle while the frame queue has room.
// A footer on a full store yields 16 channel results; with the back end idle the first is
// valid once the frame has passed the queue, the shift register and the result register,
// then one per cycle while m_ready is high. Bytes stall only when two frames wait in the queue.
// aresetn is synchronous, active low: it clears fill index, queue and output valid and sets
// registers to their defaults. The frame store has no reset and needs no clearing pass.
module sbus_frame_decoder #(
    parameter int QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Byte input channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_rx_byte,
    // Channel result channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sfd_pkg::CH_IDX_W-1:0]      m_channel_index,
    output logic [sfd_pkg::CH_W-1:0]          m_channel_value,
    output logic                              m_digital_ch17,
    output logic                              m_digital_ch18,
    output logic                              m_frame_lost,
    output logic                              m_failsafe_active,
    output logic                              m_last_channel
);

    logic [7:0]               header_reg;
    logic [7:0]               footer_reg;
    logic [sfd_pkg::CH_W-1:0] failsafe_reg;

    logic            byte_accept;
    logic            frame_push;
    logic            frame_pop;
    logic            q_not_empty;
    logic            q_full;
    sfd_pkg::frame_t front_frame;
    sfd_pkg::frame_t back_frame;

    // Configuration is always taken; writes to an unknown index are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg   <= sfd_pkg::HEADER_RESET;
            footer_reg   <= sfd_pkg::FOOTER_RESET;
            failsafe_reg <= sfd_pkg::FAILSAFE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                sfd_pkg::CFG_HEADER:   header_reg   <= cfg_data[7:0];
                sfd_pkg::CFG_FOOTER:   footer_reg   <= cfg_data[7:0];
                sfd_pkg::CFG_FAILSAFE: failsafe_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A byte request is taken whenever the queue could hold a new frame. This is
    // slightly conservative: a byte that would not complete a frame is also held
    // off while the queue is full, which keeps the handshake free of compares.
    assign s_ready     = !q_full;
    assign byte_accept = s_valid && s_ready;

    sfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_rx_byte),
        .header_byte (header_reg),
        .footer_byte (footer_reg),
        .frame_push  (frame_push),
        .frame_data  (front_frame)
    );

    // The queue holds complete frame snapshots, so the front end may refill the
    // store with the next frame while the back end is still emitting this one.
    sfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (frame_push),
        .push_data (front_frame),
        .pop       (frame_pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .pop_data  (back_frame)
    );

    sfd_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .frame_avail       (q_not_empty),
        .frame_data        (back_frame),
        .frame_pop         (frame_pop),
        .failsafe_value    (failsafe_reg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_channel_index   (m_channel_index),
        .m_channel_value   (m_channel_value),
        .m_digital_ch17    (m_digital_ch17),
        .m_digital_ch18    (m_digital_ch18),
        .m_frame_lost      (m_frame_lost),
        .m_failsafe_active (m_failsafe_active),
        .m_last_channel    (m_last_channel)
    );

    // The last-channel marker sits only on the final channel of a frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_channel |->
            m_channel_index == sfd_pkg::CH_IDX_W'(sfd_pkg::NUM_CHANNELS - 1))
        else $error("last_channel on a channel other than the final one");

    // While failsafe is flagged every channel carries the configured value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_failsafe_active |-> m_channel_value == failsafe_reg)
        else $error("failsafe channel value differs from the configured value");

    // Back-to-back results within one frame step the channel index by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_channel |=>
            !m_valid ||
            m_channel_index == sfd_pkg::CH_IDX_W'($past(m_channel_index) + 1'b1))
        else $error("channel index did not advance by one");

    // A frame is only captured when the queue has room for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        frame_push |-> !q_full)
        else $error("frame captured into a full queue");

endmodule
